// File: rtl/pts_pkg.sv
package pts_pkg;

	localparam int SLOTS  = 16;
	localparam int SLOT_W = $clog2(SLOTS);

	typedef enum logic [1:0] {
		MODE_TICK     = 2'd0,
		MODE_ADD      = 2'd1,
		MODE_DEL      = 2'd2,
		MODE_DISPATCH = 2'd3
	} mode_e_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_RUN         = 3'd1,
		ST_FULL        = 3'd2,
		ST_NOT_FOUND   = 3'd3,
		ST_NOTHING_DUE = 3'd4
	} status_e_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_SCAN = 1'b1
	} state_e_t;

	// controller to datapath
	typedef struct packed {
		logic               load;
		logic               apply;
		logic               emit;
		status_e_t          emit_status;
		logic               emit_last;
		logic               emit_slot;
		logic [SLOT_W-1:0]  slot;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		mode_e_t mode;
		logic    hit;
		logic    more_due;
		logic    out_free;
	} dp_stat_t;

endpackage

// File: rtl/pts_req_if.sv
interface pts_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [7:0]  task_id;
	logic [31:0] start_delay;
	logic [31:0] repeat_period;

	modport source (output valid, output mode, output task_id, output start_delay,
		output repeat_period, input ready);
	modport sink (input valid, input mode, input task_id, input start_delay,
		input repeat_period, output ready);
endinterface

// File: rtl/pts_rsp_if.sv
interface pts_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [7:0] run_id;
	logic [3:0] slot_index;
	logic       last;

	modport source (output valid, output status, output run_id, output slot_index,
		output last, input ready);
	modport sink (input valid, input status, input run_id, input slot_index,
		input last, output ready);
endinterface

// File: rtl/periodic_task_scheduler_table_unit.sv
// Periodic task scheduler table: sixteen task slots, each with an id, a countdown
// delay, a reload period and a saturating count of pending runs. An item carries
// a mode: tick advances every used slot, add fills the lowest free slot, delete
// frees the lowest used slot with a matching id, dispatch emits one run result per
// due slot in ascending slot order (last marks the final one, or a single
// nothing-due result). A single slot unit walks the table one slot per cycle
// while no emitting step holds: tick walks all sixteen slots, add and delete
// end at the slot they hit, dispatch ends at the last due slot. Each result
// waits in a one-deep output register; while that register is full and not
// taken, a scan step that must emit holds, and the next item is accepted as
// soon as the current one has placed its final result.
module periodic_task_scheduler_table_unit (
	input logic clk,
	input logic arst_n,
	pts_req_if.sink   req,
	pts_rsp_if.source rsp
);
	import pts_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencer: walks the slot index and decides apply/emit per step
	pts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// slot table, latched item and result register
	pts_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.mode          (req.mode),
		.task_id       (req.task_id),
		.start_delay   (req.start_delay),
		.repeat_period (req.repeat_period),
		.rsp_valid     (rsp.valid),
		.rsp_ready     (rsp.ready),
		.status        (rsp.status),
		.run_id        (rsp.run_id),
		.slot_index    (rsp.slot_index),
		.last          (rsp.last)
	);

endmodule

// File: rtl/pts_dpath.sv
module pts_dpath (
	input  logic              clk,
	input  logic              arst_n,
	input  pts_pkg::dp_cmd_t  cmd,
	output pts_pkg::dp_stat_t stat,
	input  logic [1:0]        mode,
	input  logic [7:0]        task_id,
	input  logic [31:0]       start_delay,
	input  logic [31:0]       repeat_period,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output logic [2:0]        status,
	output logic [7:0]        run_id,
	output logic [3:0]        slot_index,
	output logic              last
);
	import pts_pkg::*;

	// slot table
	logic        used_q    [SLOTS];
	logic [7:0]  task_q    [SLOTS];
	logic [31:0] delay_q   [SLOTS];
	logic [31:0] period_q  [SLOTS];
	logic [7:0]  pending_q [SLOTS];

	// latched item
	mode_e_t     mode_q;
	logic [7:0]  id_q;
	logic [31:0] dly_q;
	logic [31:0] per_q;

	// result register
	logic        out_valid_q;
	status_e_t   out_status_q;
	logic [7:0]  out_id_q;
	logic [3:0]  out_slot_q;
	logic        out_last_q;

	logic [SLOTS-1:0] due;
	logic [SLOTS-1:0] due_hi;
	logic             hit;

	always_comb begin
		for (int j = 0; j < SLOTS; j++) begin
			due[j] = used_q[j] && (pending_q[j] != 8'd0);
		end
	end

	assign due_hi = due >> cmd.slot;

	always_comb begin
		unique case (mode_q)
			MODE_TICK:     hit = used_q[cmd.slot];
			MODE_ADD:      hit = !used_q[cmd.slot];
			MODE_DEL:      hit = used_q[cmd.slot] && (task_q[cmd.slot] == id_q);
			MODE_DISPATCH: hit = due[cmd.slot];
			default:       hit = 1'b0;
		endcase
	end

	assign stat.mode     = mode_q;
	assign stat.hit      = hit;
	assign stat.more_due = |due_hi[SLOTS-1:1];
	assign stat.out_free = !out_valid_q || rsp_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode_e_t'(mode);
			id_q   <= task_id;
			dly_q  <= start_delay;
			per_q  <= repeat_period;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < SLOTS; j++) begin
				used_q[j] <= 1'b0;
			end
		end else if (cmd.apply) begin
			case (mode_q)
				MODE_ADD: used_q[cmd.slot] <= 1'b1;
				MODE_DEL: used_q[cmd.slot] <= 1'b0;
				MODE_DISPATCH: begin
					// one-shot slots drop out after their run
					if (period_q[cmd.slot] == 32'd0) begin
						used_q[cmd.slot] <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			case (mode_q)
				MODE_TICK: begin
					if (used_q[cmd.slot]) begin
						if (delay_q[cmd.slot] == 32'd0) begin
							delay_q[cmd.slot] <= period_q[cmd.slot];
							if (pending_q[cmd.slot] != 8'hFF) begin
								pending_q[cmd.slot] <= pending_q[cmd.slot] + 8'd1;
							end
						end else begin
							delay_q[cmd.slot] <= delay_q[cmd.slot] - 32'd1;
						end
					end
				end
				MODE_ADD: begin
					task_q[cmd.slot]    <= id_q;
					delay_q[cmd.slot]   <= dly_q;
					period_q[cmd.slot]  <= per_q;
					pending_q[cmd.slot] <= 8'd0;
				end
				MODE_DISPATCH: pending_q[cmd.slot] <= pending_q[cmd.slot] - 8'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_status_q <= cmd.emit_status;
			out_id_q     <= (cmd.emit_status == ST_RUN) ? task_q[cmd.slot] : 8'd0;
			out_slot_q   <= cmd.emit_slot ? 4'(cmd.slot) : 4'd0;
			out_last_q   <= cmd.emit_last;
		end
	end

	assign rsp_valid  = out_valid_q;
	assign status     = out_status_q;
	assign run_id     = out_id_q;
	assign slot_index = out_slot_q;
	assign last       = out_last_q;

endmodule

// File: rtl/pts_ctrl.sv
module pts_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  pts_pkg::dp_stat_t stat,
	output pts_pkg::dp_cmd_t  cmd
);
	import pts_pkg::*;

	state_e_t          state_q, state_d;
	logic [SLOT_W-1:0] idx_q, idx_d;
	logic              last_slot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	assign last_slot = (idx_q == SLOT_W'(SLOTS - 1));

	always_comb begin
		state_d         = state_q;
		idx_d           = idx_q;
		req_ready       = 1'b0;
		cmd             = '0;
		cmd.slot        = idx_q;
		cmd.emit_status = ST_OK;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					idx_d    = '0;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				unique case (stat.mode) inside
					MODE_TICK: begin
						if (!last_slot) begin
							cmd.apply = 1'b1;
							idx_d     = idx_q + SLOT_W'(1);
						end else if (stat.out_free) begin
							cmd.apply     = 1'b1;
							cmd.emit      = 1'b1;
							cmd.emit_last = 1'b1;
							state_d       = S_IDLE;
						end
					end
					MODE_ADD, MODE_DEL: begin
						if (stat.hit) begin
							if (stat.out_free) begin
								cmd.apply     = 1'b1;
								cmd.emit      = 1'b1;
								cmd.emit_last = 1'b1;
								cmd.emit_slot = 1'b1;
								state_d       = S_IDLE;
							end
						end else if (last_slot) begin
							if (stat.out_free) begin
								cmd.emit        = 1'b1;
								cmd.emit_last   = 1'b1;
								cmd.emit_status = (stat.mode == MODE_ADD) ? ST_FULL : ST_NOT_FOUND;
								state_d         = S_IDLE;
							end
						end else begin
							idx_d = idx_q + SLOT_W'(1);
						end
					end
					MODE_DISPATCH: begin
						if (stat.hit) begin
							if (stat.out_free) begin
								cmd.apply       = 1'b1;
								cmd.emit        = 1'b1;
								cmd.emit_status = ST_RUN;
								cmd.emit_slot   = 1'b1;
								cmd.emit_last   = !stat.more_due;
								if (stat.more_due) begin
									idx_d = idx_q + SLOT_W'(1);
								end else begin
									state_d = S_IDLE;
								end
							end
						end else if (last_slot) begin
							if (stat.out_free) begin
								cmd.emit        = 1'b1;
								cmd.emit_last   = 1'b1;
								cmd.emit_status = ST_NOTHING_DUE;
								state_d         = S_IDLE;
							end
						end else begin
							idx_d = idx_q + SLOT_W'(1);
						end
					end
					default: ;
				endcase
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// File: test/pts_checker.sv
module pts_checker (
	input  logic clk,
	input  logic arst_n,
	pts_req_if   req,
	pts_rsp_if   rsp,
	output int   fail_count,
	output int   owed
);
	import pts_pkg::*;

	typedef struct packed {
		status_e_t  status;
		logic [7:0] run_id;
		logic [3:0] slot_index;
		logic       last;
	} result_t;

	// shadow copy of the task table
	logic        used_r   [SLOTS];
	logic [7:0]  task_r   [SLOTS];
	logic [31:0] delay_r  [SLOTS];
	logic [31:0] period_r [SLOTS];
	logic [7:0]  pend_r   [SLOTS];

	result_t owed_q[$];

	function automatic result_t make_result(input status_e_t s, input logic [7:0] id,
			input int slot, input logic fin);
		result_t r;
		r.status     = s;
		r.run_id     = id;
		r.slot_index = 4'(slot);
		r.last       = fin;
		return r;
	endfunction

	// advance the table by one item and queue what it must produce
	task automatic schedule_step(input mode_e_t m, input logic [7:0] id,
			input logic [31:0] dly, input logic [31:0] per);
		int hit;
		int last_due;
		hit      = -1;
		last_due = -1;
		case (m)
		MODE_TICK: begin
			for (int i = 0; i < SLOTS; i++) begin
				if (used_r[i]) begin
					if (delay_r[i] == 32'd0) begin
						delay_r[i] = period_r[i];
						if (pend_r[i] != 8'hFF)
							pend_r[i]++;
					end else begin
						delay_r[i]--;
					end
				end
			end
			owed_q.push_back(make_result(ST_OK, 8'h00, 0, 1'b1));
		end
		MODE_ADD: begin
			for (int i = 0; i < SLOTS && hit < 0; i++)
				if (!used_r[i])
					hit = i;
			if (hit < 0) begin
				owed_q.push_back(make_result(ST_FULL, 8'h00, 0, 1'b1));
			end else begin
				used_r[hit]   = 1'b1;
				task_r[hit]   = id;
				delay_r[hit]  = dly;
				period_r[hit] = per;
				pend_r[hit]   = 8'h00;
				owed_q.push_back(make_result(ST_OK, 8'h00, hit, 1'b1));
			end
		end
		MODE_DEL: begin
			for (int i = 0; i < SLOTS && hit < 0; i++)
				if (used_r[i] && task_r[i] == id)
					hit = i;
			if (hit < 0) begin
				owed_q.push_back(make_result(ST_NOT_FOUND, 8'h00, 0, 1'b1));
			end else begin
				used_r[hit] = 1'b0;
				owed_q.push_back(make_result(ST_OK, 8'h00, hit, 1'b1));
			end
		end
		default: begin
			for (int i = 0; i < SLOTS; i++)
				if (used_r[i] && pend_r[i] != 8'h00)
					last_due = i;
			if (last_due < 0) begin
				owed_q.push_back(make_result(ST_NOTHING_DUE, 8'h00, 0, 1'b1));
			end else begin
				for (int i = 0; i < SLOTS; i++) begin
					if (used_r[i] && pend_r[i] != 8'h00) begin
						pend_r[i]--;
						owed_q.push_back(make_result(ST_RUN, task_r[i], i, i == last_due));
						// one-shot drops whatever runs remain
						if (period_r[i] == 32'd0)
							used_r[i] = 1'b0;
					end
				end
			end
		end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t want;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				used_r[i]   = 1'b0;
				task_r[i]   = 8'h00;
				delay_r[i]  = 32'd0;
				period_r[i] = 32'd0;
				pend_r[i]   = 8'h00;
			end
			owed_q.delete();
			fail_count = 0;
		end else begin
			if (req.valid && req.ready)
				schedule_step(mode_e_t'(req.mode), req.task_id, req.start_delay,
					req.repeat_period);
			if (rsp.valid && rsp.ready) begin
				got.status     = status_e_t'(rsp.status);
				got.run_id     = rsp.run_id;
				got.slot_index = rsp.slot_index;
				got.last       = rsp.last;
				if (owed_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result: status %0d run_id %0d slot %0d last %0d",
							got.status, got.run_id, got.slot_index, got.last);
					fail_count++;
				end else begin
					want = owed_q.pop_front();
					if (got.status !== want.status || got.run_id !== want.run_id ||
							got.slot_index !== want.slot_index || got.last !== want.last) begin
						if (fail_count < 10)
							$display("mismatch: expected status %0d run_id %0d slot %0d last %0d, got status %0d run_id %0d slot %0d last %0d",
								want.status, want.run_id, want.slot_index, want.last,
								got.status, got.run_id, got.slot_index, got.last);
						fail_count++;
					end
				end
			end
		end
		owed = owed_q.size();
	end

endmodule

// File: test/periodic_task_scheduler_table_unit_tb.sv
module periodic_task_scheduler_table_unit_tb;
	import pts_pkg::*;

	localparam int IDLE_LIMIT   = 2000;  // cycles with no item moving on either side
	localparam int LONG_HOLD    = 300;   // one long receiver stall to back up the block
	localparam int DRAIN_WAIT   = 40;    // margin after the last owed result to catch any extra results
	localparam int RANDOM_ITEMS = 190;

	logic clk = 1'b0;
	logic arst_n;
	int   fail_count;
	int   owed;
	int   quiet_cycles = 0;
	logic gapless_send = 1'b0;

	pts_req_if req();
	pts_rsp_if rsp();

	periodic_task_scheduler_table_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// predicts from accepted items and checks every result
	pts_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.fail_count (fail_count),
		.owed       (owed)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog: a hang shows up as a long stretch with nothing accepted
	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// offer one item after a random gap, return at the edge that takes it
	task automatic offer_item(input mode_e_t m, input logic [7:0] id,
			input logic [31:0] dly, input logic [31:0] per);
		int gap;
		// now and then switch between gapped and back-to-back runs
		if ($urandom_range(0, 15) == 0)
			gapless_send = !gapless_send;
		gap = gapless_send ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid         <= 1'b1;
		req.mode          <= m;
		req.task_id       <= id;
		req.start_delay   <= dly;
		req.repeat_period <= per;
		do @(posedge clk); while (!req.ready);
	endtask

	// random item; filling leans on adds, draining on deletes and dispatches
	task automatic offer_random(input bit filling);
		int          pick;
		mode_e_t     m;
		logic [7:0]  id;
		logic [31:0] dly;
		logic [31:0] per;
		pick = $urandom_range(0, 99);
		if (filling)
			m = pick < 55 ? MODE_ADD : pick < 75 ? MODE_TICK :
				pick < 90 ? MODE_DISPATCH : MODE_DEL;
		else
			m = pick < 15 ? MODE_ADD : pick < 45 ? MODE_TICK :
				pick < 75 ? MODE_DISPATCH : MODE_DEL;
		// a small id pool makes deletes hit and duplicates common
		id  = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
		// mostly short delays and periods so slots come due; sometimes full width
		dly = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 3);
		per = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 3);
		offer_item(m, id, dly, per);
	endtask

	// sender: reset, directed items, fill, random phases, end
	initial begin
		arst_n            = 1'b0;
		req.valid         <= 1'b0;
		req.mode          <= MODE_TICK;
		req.task_id       <= 8'h00;
		req.start_delay   <= 32'd0;
		req.repeat_period <= 32'd0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table: nothing due, delete misses, tick does nothing
		offer_item(MODE_DISPATCH, 8'h00, 32'd0, 32'd0);
		offer_item(MODE_DEL, 8'h5A, 32'd0, 32'd0);
		offer_item(MODE_TICK, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

		// one-shot, extreme fields, duplicate ids, huge period
		offer_item(MODE_ADD, 8'hFF, 32'd0, 32'd0);
		offer_item(MODE_ADD, 8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		offer_item(MODE_ADD, 8'hA5, 32'd1, 32'd2);
		offer_item(MODE_ADD, 8'hA5, 32'd0, 32'd1);
		offer_item(MODE_ADD, 8'h3C, 32'd0, 32'hFFFF_FFFF);

		// two ticks give the one-shot two pending runs; dispatch runs it once
		offer_item(MODE_TICK, 8'h00, 32'd0, 32'd0);
		offer_item(MODE_TICK, 8'h00, 32'd0, 32'd0);
		offer_item(MODE_DISPATCH, 8'h00, 32'd0, 32'd0);

		// duplicates: each delete takes the lowest match, then a miss
		offer_item(MODE_DEL, 8'hA5, 32'd0, 32'd0);
		offer_item(MODE_DEL, 8'hA5, 32'd0, 32'd0);
		offer_item(MODE_DEL, 8'hA5, 32'd0, 32'd0);

		// fill the table; the last three adds hit table full
		for (int i = 0; i <= SLOTS; i++)
			offer_item(MODE_ADD, 8'(8'h10 + i), 32'(i % 3), 32'(i % 4));

		// random part, alternating fill-leaning and drain-leaning stretches
		for (int i = 0; i < RANDOM_ITEMS; i++)
			offer_random((i % 80) >= 40);

		req.valid <= 1'b0;
		@(posedge clk);
		while (owed != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// receiver: random stalls per item, gapless stretches, one long hold-off
	initial begin
		int stall;
		int taken;
		bit held;
		bit gapless_take;
		taken        = 0;
		held         = 1'b0;
		gapless_take = 1'b0;
		rsp.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			// long stall while the sender keeps offering: output fills, input backs up
			if (!held && taken >= 30) begin
				held = 1'b1;
				rsp.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			if ($urandom_range(0, 15) == 0)
				gapless_take = !gapless_take;
			stall = gapless_take ? 0 : $urandom_range(0, 10);
			if (stall > 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!rsp.valid);
			taken++;
		end
	end

endmodule

// File: periodic_task_scheduler_table_unit.f
rtl/pts_pkg.sv
rtl/pts_req_if.sv
rtl/pts_rsp_if.sv
rtl/pts_dpath.sv
rtl/pts_ctrl.sv
rtl/periodic_task_scheduler_table_unit.sv
test/pts_checker.sv
test/periodic_task_scheduler_table_unit_tb.sv
